// ----- rtl/cimdr_pkg.sv -----
package cimdr_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned NarrowWidth = 32;
   localparam int unsigned DivBitsPerStage = 2;

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_DIV = 2'd1,
      OP_REM = 2'd2,
      OP_RSV = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] op;
      logic is_signed;
      logic is_wide;
      logic [DataWidth-1:0] left_operand;
      logic [DataWidth-1:0] right_operand;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result_value;
      logic would_trap;
   } rsp_type;

   // control that travels beside the datapath
   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic is_rem;
      logic is_wide;
      logic neg_q;
      logic neg_r;
      logic zero_div;
      logic trap;
   } ctl_type;

endpackage

// ----- rtl/checked_integer_mul_div_rem_top.sv -----
// Checked integer multiply / divide / remainder, 32 or 64 bits.
// Input channel req_*: one item per cycle while req_stall is low, carrying
// op, signedness, width and two operands. Result channel rsp_*: one item
// per input, in order, with the wrapped result and a trap flag (zero
// divisor or signed minimum by -1). Zero divisor returns 0; signed
// minimum / -1 returns the minimum.
// Stages = DataWidth / DivBitsPerStage. The pipe holds Stages + 2
// registers: an operand-prep stage, 32 restoring-divide stages of two
// quotient bits each, and an output fix stage.
// The multiplier is three 32x32 partial products formed in the prep stage,
// summed over the next two stages, and carried down the pipe.
// Throughput: one item per clock, and an item is accepted every cycle that
// req_stall is low. Stall: rsp_stall holds the full stages nearest the
// output; req_stall is raised only when the pipe is full and the output is
// blocked, so nothing is lost or repeated; bubbles close up while stalled.
// Reset: synchronous, active high; clears all stage valid bits.
module checked_integer_mul_div_rem_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  cimdr_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output cimdr_pkg::rsp_type rsp_data
);
   localparam int unsigned W = cimdr_pkg::DataWidth;
   localparam int unsigned H = cimdr_pkg::NarrowWidth;
   localparam int unsigned K = cimdr_pkg::DivBitsPerStage;
   localparam int unsigned Stages = W / K;
   localparam int unsigned Depth = Stages + 2;

   // per-stage state: remainder, quotient/dividend shift reg, divisor
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] adv;
   cimdr_pkg::ctl_type ctl_ff [Depth];
   logic [W-1:0] rem_ff [Depth];
   logic [W-1:0] quo_ff [Depth];
   logic [W-1:0] dvs_ff [Depth];
   logic [W-1:0] mul_ff [Depth];
   logic [2*H-1:0] pp_ff [4];

   // stall chain: a stage moves when the next one is empty or moving
   always_comb begin
      adv[Depth-1] = !vld_ff[Depth-1] || !rsp_stall;
      for (int i = Depth - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end
   assign req_stall = !adv[0];

   // operand prep
   logic [W-1:0] a_m, b_m, minv, a_abs, b_abs;
   logic na, nb;
   cimdr_pkg::ctl_type ctl_in;
   always_comb begin
      minv = req_data.is_wide ? {1'b1, {(W-1){1'b0}}} : W'({1'b1, {(H-1){1'b0}}});
      a_m = req_data.is_wide ? req_data.left_operand :
            {{(W-H){1'b0}}, req_data.left_operand[H-1:0]};
      b_m = req_data.is_wide ? req_data.right_operand :
            {{(W-H){1'b0}}, req_data.right_operand[H-1:0]};
      na = req_data.is_signed && ((a_m & minv) != '0);
      nb = req_data.is_signed && ((b_m & minv) != '0);
      a_abs = na ? (req_data.is_wide ? -a_m : {{(W-H){1'b0}}, -a_m[H-1:0]}) : a_m;
      b_abs = nb ? (req_data.is_wide ? -b_m : {{(W-H){1'b0}}, -b_m[H-1:0]}) : b_m;
      ctl_in.is_mul = req_data.op == cimdr_pkg::OP_MUL;
      ctl_in.is_div = req_data.op == cimdr_pkg::OP_DIV;
      ctl_in.is_rem = req_data.op == cimdr_pkg::OP_REM;
      ctl_in.is_wide = req_data.is_wide;
      ctl_in.neg_q = na ^ nb;
      ctl_in.neg_r = na;
      ctl_in.zero_div = b_m == '0;
      ctl_in.trap = (ctl_in.is_div || ctl_in.is_rem) && ((b_m == '0) ||
         (req_data.is_signed && a_m == minv &&
          b_m == (req_data.is_wide ? {W{1'b1}} : W'({H{1'b1}}))));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < Depth; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // divide stages, K quotient bits each
   logic [W-1:0] r_n [Depth];
   logic [W-1:0] q_n [Depth];
   always_comb begin
      for (int s = 1; s <= Stages; s++) begin
         logic [W:0] r;
         logic [W-1:0] q;
         logic [W:0] d;
         r = {1'b0, rem_ff[s-1]};
         q = quo_ff[s-1];
         for (int k = 0; k < K; k++) begin
            r = {r[W-1:0], q[W-1]};
            q = {q[W-2:0], 1'b0};
            d = r - {1'b0, dvs_ff[s-1]};
            if (!d[W]) begin
               r = d;
               q[0] = 1'b1;
            end
         end
         r_n[s] = r[W-1:0];
         q_n[s] = q;
      end
      r_n[0] = '0;
      q_n[0] = '0;
      r_n[Depth-1] = '0;
      q_n[Depth-1] = '0;
   end

   // output fix stage
   logic [W-1:0] res;
   always_comb begin
      logic [W-1:0] q, r, v;
      q = quo_ff[Stages];
      r = rem_ff[Stages];
      v = '0;
      if (ctl_ff[Stages].is_mul) begin
         v = mul_ff[Stages];
      end else if (ctl_ff[Stages].zero_div) begin
         v = '0;
      end else if (ctl_ff[Stages].is_div) begin
         v = ctl_ff[Stages].neg_q ? -q : q;
      end else if (ctl_ff[Stages].is_rem) begin
         v = ctl_ff[Stages].neg_r ? -r : r;
      end
      res = ctl_ff[Stages].is_wide ? v : {{(W-H){1'b0}}, v[H-1:0]};
   end

   // datapath registers, all stages
   always_ff @(posedge clock) begin
      // stage 0: prepped operands and partial products
      if (adv[0]) begin
         ctl_ff[0] <= ctl_in;
         rem_ff[0] <= '0;
         quo_ff[0] <= a_abs;
         dvs_ff[0] <= b_abs;
         pp_ff[0] <= a_m[H-1:0] * b_m[H-1:0];
         pp_ff[1] <= a_m[W-1:H] * b_m[H-1:0];
         pp_ff[2] <= a_m[H-1:0] * b_m[W-1:H];
         mul_ff[0] <= '0;
      end
      for (int s = 1; s <= Stages; s++) begin
         if (adv[s]) begin
            ctl_ff[s] <= ctl_ff[s-1];
            rem_ff[s] <= r_n[s];
            quo_ff[s] <= q_n[s];
            dvs_ff[s] <= dvs_ff[s-1];
            if (s == 1) begin
               mul_ff[s] <= pp_ff[0] + {pp_ff[1][H-1:0], {H{1'b0}}};
               pp_ff[3] <= pp_ff[2];
            end else if (s == 2) begin
               mul_ff[s] <= mul_ff[s-1] + {pp_ff[3][H-1:0], {H{1'b0}}};
            end else begin
               mul_ff[s] <= mul_ff[s-1];
            end
         end
      end
      if (adv[Depth-1]) begin
         ctl_ff[Depth-1] <= ctl_ff[Stages];
         mul_ff[Depth-1] <= res;
         rem_ff[Depth-1] <= '0;
         quo_ff[Depth-1] <= '0;
         dvs_ff[Depth-1] <= '0;
      end
   end

   assign rsp_valid = vld_ff[Depth-1];
   assign rsp_data.result_value = mul_ff[Depth-1];
   assign rsp_data.would_trap = ctl_ff[Depth-1].trap;
   logic unused_ok;
   assign unused_ok = ^{r_n[0], q_n[0], r_n[Depth-1], q_n[Depth-1]};
endmodule
